/* design/length_prefixed_record_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed record deframer
// Expect clk and rst_n in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lprd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and codes of the length-prefixed record deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

    // Action codes passed from the parser to the result stage
    typedef logic [1:0] op_t;
    localparam op_t OP_DATA     = 2'd0;  // payload byte, last result of its word
    localparam op_t OP_DATA_END = 2'd1;  // payload byte followed by a record end
    localparam op_t OP_REC_END  = 2'd2;  // record end alone
    localparam op_t OP_EOF      = 2'd3;  // end of file

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DATA    = 2'd0;
    localparam kind_t KIND_REC_END = 2'd1;
    localparam kind_t KIND_EOF     = 2'd2;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [15:0] END_LENGTH   = 16'hFFFF;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } act_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* design/lprd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_front
// Record parser: tracks the header, payload and pad bytes of each record
// and turns every byte that causes results into one action word.
// ----------------------------------------------------------------------------
module lprd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_mode_we,
    input  logic              text_mode_wdata,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output logic              enq,
    output lprd_pkg::act_t    enq_act
);

    localparam logic [2:0] PH_LEN_HI = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_EOF    = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remain_reg, remain_next;
    logic        pad_reg, pad_next;
    logic        text_reg;

    logic [15:0] len_word;
    logic [15:0] remain_dec;

    assign len_word   = {len_hi_reg, data_byte};
    assign remain_dec = remain_reg - 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        len_hi_next  = len_hi_reg;
        remain_next  = remain_reg;
        pad_next     = pad_reg;
        enq          = 1'b0;
        enq_act.op   = lprd_pkg::OP_DATA;
        enq_act.data = data_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    len_hi_next = data_byte;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (len_word == lprd_pkg::END_LENGTH)
                    begin
                        phase_next = PH_EOF;
                        enq        = 1'b1;
                        enq_act.op = lprd_pkg::OP_EOF;
                    end
                    else if (len_word == 16'd0)
                    begin
                        phase_next = PH_LEN_HI;
                        enq        = text_reg;
                        enq_act.op = lprd_pkg::OP_REC_END;
                    end
                    else
                    begin
                        remain_next = len_word;
                        pad_next    = len_word[0];
                        phase_next  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    remain_next = remain_dec;
                    enq         = 1'b1;
                    if (remain_dec == 16'd0)
                    begin
                        phase_next = pad_reg ? PH_PAD : PH_LEN_HI;
                        pad_next   = 1'b0;
                        enq_act.op = text_reg ? lprd_pkg::OP_DATA_END : lprd_pkg::OP_DATA;
                    end
                end
                PH_PAD:
                begin
                    // drop the pad byte
                    phase_next = PH_LEN_HI;
                end
                default:
                begin
                    // end of file: ignore everything
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN_HI;
            len_hi_reg <= 8'd0;
            remain_reg <= 16'd0;
            pad_reg    <= 1'b0;
            text_reg   <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
            pad_reg    <= pad_next;
            if (text_mode_we)
            begin
                text_reg <= text_mode_wdata;
            end
        end
    end

endmodule

/* design/lprd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_queue
// Small action queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module lprd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enq,
    input  lprd_pkg::act_t       enq_act,
    input  logic                 deq,
    output lprd_pkg::act_t       head,
    output lprd_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lprd_pkg::act_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (deq)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (enq && !deq)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (deq && !enq)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/lprd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_back
// Result stage: expands action words into result words and holds the
// current one in an output register.
// ----------------------------------------------------------------------------
`include "length_prefixed_record_deframer_defines.svh"

module lprd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lprd_pkg::act_t       head,
    input  lprd_pkg::q_status_t  q_status,
    output logic                 deq,
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           out_byte,
    output logic [1:0]           kind,
    output logic                 last
);

    logic       valid_reg;
    logic       pend_reg;     // record end still owed after a payload word
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic       last_reg;
    logic       load;

    assign load  = !valid_reg || pop;
    assign deq   = load && !pend_reg && !q_status.empty;

    assign empty    = !valid_reg;
    assign out_byte = byte_reg;
    assign kind     = kind_reg;
    assign last     = last_reg;

    always_ff @(posedge clk)
    begin
        if (load && pend_reg)
        begin
            byte_reg <= lprd_pkg::NEWLINE_CODE;
            kind_reg <= lprd_pkg::KIND_REC_END;
            last_reg <= 1'b1;
        end
        else if (deq)
        begin
            case (head.op)
                lprd_pkg::OP_DATA:
                begin
                    byte_reg <= head.data;
                    kind_reg <= lprd_pkg::KIND_DATA;
                    last_reg <= 1'b1;
                end
                lprd_pkg::OP_DATA_END:
                begin
                    byte_reg <= head.data;
                    kind_reg <= lprd_pkg::KIND_DATA;
                    last_reg <= 1'b0;
                end
                lprd_pkg::OP_REC_END:
                begin
                    byte_reg <= lprd_pkg::NEWLINE_CODE;
                    kind_reg <= lprd_pkg::KIND_REC_END;
                    last_reg <= 1'b1;
                end
                default:
                begin
                    byte_reg <= 8'd0;
                    kind_reg <= lprd_pkg::KIND_EOF;
                    last_reg <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !q_status.empty;
                pend_reg  <= deq && (head.op == lprd_pkg::OP_DATA_END);
            end
        end
    end

    `LPRD_ASSERT_NOW(a_pend_shape, pend_reg, valid_reg && kind_reg == lprd_pkg::KIND_DATA && !last_reg, "owed record end without a pending payload word")
    `LPRD_ASSERT_NEXT(a_pend_follow, pend_reg && pop, valid_reg && kind_reg == lprd_pkg::KIND_REC_END && last_reg, "record end did not follow its payload word")
    `LPRD_ASSERT_NOW(a_eof_shape, valid_reg && kind_reg == lprd_pkg::KIND_EOF, byte_reg == 8'd0 && last_reg && !pend_reg, "malformed end of file word")

endmodule

/* design/length_prefixed_record_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer
// Strips 16-bit big-endian length headers and pad bytes from a record stream.
// ----------------------------------------------------------------------------
// Takes one input byte per clock while full is low and passes payload bytes
// on; a length of 0xFFFF raises a single end-of-file word and every later
// byte is dropped until reset. With text_mode set, a record-end word (value
// 10) follows each record, zero-length ones included. Bytes flow at one per
// cycle while full is low; the last payload byte of a record in text mode
// yields two result words, which leave in turn through the single output
// register. A queue of QUEUE_DEPTH action words between the parser and the
// output register absorbs the extra word; result words pass from a queue
// entry into the output register. The user must keep text_mode written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_mode_we,
    input  logic        text_mode_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [1:0]  kind,
    output logic        last
);

    logic                accept;
    logic                enq;
    logic                deq;
    lprd_pkg::act_t      enq_act;
    lprd_pkg::act_t      head;
    lprd_pkg::q_status_t q_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    lprd_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_mode_we    (text_mode_we),
        .text_mode_wdata (text_mode_wdata),
        .accept          (accept),
        .data_byte       (data_byte),
        .enq             (enq),
        .enq_act         (enq_act)
    );

    lprd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_act (enq_act),
        .deq     (deq),
        .head    (head),
        .status  (q_status)
    );

    lprd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .deq      (deq),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .kind     (kind),
        .last     (last)
    );

endmodule
